@@ rtl/windowed_moving_average_ring_defines.svh @@
// assertion macros for the moving average ring checker
// expects clk and rst_n in the scope of each use
`ifndef WINDOWED_MOVING_AVERAGE_RING_DEFINES_SVH
`define WINDOWED_MOVING_AVERAGE_RING_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define WMAR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average ring: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define WMAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average ring: next-cycle check failed");

`endif

@@ rtl/wmar_pkg.sv @@
// shared constants, types and helpers for the moving average ring
// no dependencies
`default_nettype none

package wmar_pkg;

    // store geometry
    localparam int DEPTH       = 128;
    localparam int SAMPLE_BITS = 16;

    // port field widths
    localparam int IN_BITS  = 16;
    localparam int WIN_BITS = 8;
    localparam int OUT_BITS = 16;

    // derived widths
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CLAMP_W = (CNT_W > WIN_BITS) ? CNT_W : WIN_BITS;
    localparam int CALC_W  = CNT_W + 1;
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int QUOT_W  = (SUM_W > OUT_BITS) ? SUM_W : OUT_BITS;
    localparam int DIVC_W  = $clog2(QUOT_W);
    localparam int WIDE_W  = (SAMPLE_BITS > IN_BITS) ? SAMPLE_BITS : IN_BITS;

    // request action codes
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [QUOT_W-1:0]      quot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // fit the input sample to the stored width
    function automatic sample_t to_sample(input logic [IN_BITS-1:0] v);
        logic [WIDE_W-1:0] t;
        t = WIDE_W'(v);
        return t[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/wmar_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module wmar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/windowed_moving_average_ring.sv @@
// moving average over a ring store of samples, top level
// depends on wmar_pkg and wmar_ram
//
//  channel   signals                                        handshake
//  request   action, sample_value, window_size              start && !busy
//  result    average_value                                  done, one cycle, no stall
//
// a push is written to the store as it is taken and leaves busy low, so requests may follow back to back
// a query reads and sums its window from the store, then divides the sum bit-serially
// over the QUOT_W (24 by default) quotient bits and raises done with the result
// an empty window answers in the next cycle; the single store read port sets the read phase
// after reset a clearing pass writes zero to every one of the DEPTH (128) slots, with busy high
// the receiver cannot stall: done is high for exactly one cycle per query
`default_nettype none

module windowed_moving_average_ring (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [15:0] sample_value,
    input  wire logic [7:0]  window_size,
    output logic             done,
    output logic      [15:0] average_value
);

    wmar_pkg::state_t state_reg, state_next;
    wmar_pkg::addr_t  addr_reg, addr_next;
    wmar_pkg::addr_t  wp_reg, wp_next;
    wmar_pkg::count_t remain_reg, remain_next;
    wmar_pkg::count_t win_reg, win_next;
    logic             pend_reg, pend_next;
    wmar_pkg::sum_t   acc_reg, acc_next;
    wmar_pkg::quot_t  q_reg, q_next;
    wmar_pkg::count_t rem_reg, rem_next;
    logic [wmar_pkg::DIVC_W-1:0] divc_reg, divc_next;

    logic                    ram_we;
    wmar_pkg::addr_t         ram_waddr;
    wmar_pkg::sample_t       ram_wdata;
    logic                    ram_re;
    wmar_pkg::sample_t       ram_rdata;

    logic                      accept;
    logic [wmar_pkg::CLAMP_W-1:0] win_wide;
    wmar_pkg::count_t          win_clamped;
    logic [wmar_pkg::CALC_W-1:0] start_calc;
    wmar_pkg::addr_t           start_addr;
    wmar_pkg::addr_t           addr_inc;
    wmar_pkg::addr_t           wp_inc;
    logic [wmar_pkg::CNT_W:0]  trial;
    logic                      trial_ge;

    // sample store
    wmar_ram #(
        .WIDTH (wmar_pkg::SAMPLE_BITS),
        .DEPTH (wmar_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // request decode, window clamp and window start
    always_comb
    begin
        accept   = start && (state_reg == wmar_pkg::ST_IDLE);
        win_wide = wmar_pkg::CLAMP_W'(window_size);
        if (win_wide > wmar_pkg::CLAMP_W'(wmar_pkg::DEPTH))
        begin
            win_clamped = wmar_pkg::CNT_W'(wmar_pkg::DEPTH);
        end
        else
        begin
            win_clamped = win_wide[wmar_pkg::CNT_W-1:0];
        end
        if (wmar_pkg::CALC_W'(wp_reg) >= wmar_pkg::CALC_W'(win_clamped))
        begin
            start_calc = wmar_pkg::CALC_W'(wp_reg) - wmar_pkg::CALC_W'(win_clamped);
        end
        else
        begin
            start_calc = wmar_pkg::CALC_W'(wp_reg) + wmar_pkg::CALC_W'(wmar_pkg::DEPTH)
                         - wmar_pkg::CALC_W'(win_clamped);
        end
        start_addr = start_calc[wmar_pkg::ADDR_W-1:0];
        addr_inc   = (addr_reg == wmar_pkg::ADDR_W'(wmar_pkg::DEPTH - 1))
                     ? '0 : addr_reg + wmar_pkg::ADDR_W'(1);
        wp_inc     = (wp_reg == wmar_pkg::ADDR_W'(wmar_pkg::DEPTH - 1))
                     ? '0 : wp_reg + wmar_pkg::ADDR_W'(1);
    end

    // restoring division step
    always_comb
    begin
        trial    = {rem_reg, q_reg[wmar_pkg::QUOT_W-1]};
        trial_ge = (trial >= (wmar_pkg::CNT_W + 1)'(win_reg));
    end

    // control state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wmar_pkg::ST_CLEAR;
            addr_reg   <= '0;
            wp_reg     <= '0;
            remain_reg <= '0;
            pend_reg   <= 1'b0;
            divc_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            wp_reg     <= wp_next;
            remain_reg <= remain_next;
            pend_reg   <= pend_next;
            divc_reg   <= divc_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        wp_next     = wp_reg;
        remain_next = remain_reg;
        pend_next   = 1'b0;
        divc_next   = divc_reg;
        win_next    = win_reg;
        acc_next    = acc_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        ram_we      = 1'b0;
        ram_waddr   = wp_reg;
        ram_wdata   = wmar_pkg::to_sample(sample_value);
        ram_re      = 1'b0;
        busy        = 1'b1;
        done        = 1'b0;

        unique case (state_reg)
            wmar_pkg::ST_CLEAR:
            begin
                // zero every slot once after reset
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = '0;
                addr_next = addr_inc;
                if (addr_reg == wmar_pkg::ADDR_W'(wmar_pkg::DEPTH - 1))
                begin
                    state_next = wmar_pkg::ST_IDLE;
                end
            end

            wmar_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    if (action == wmar_pkg::ACT_PUSH)
                    begin
                        ram_we  = 1'b1;
                        wp_next = wp_inc;
                    end
                    else if (win_clamped == '0)
                    begin
                        q_next     = '0;
                        state_next = wmar_pkg::ST_DONE;
                    end
                    else
                    begin
                        win_next    = win_clamped;
                        remain_next = win_clamped;
                        addr_next   = start_addr;
                        acc_next    = '0;
                        state_next  = wmar_pkg::ST_READ;
                    end
                end
            end

            wmar_pkg::ST_READ:
            begin
                // one store read per cycle, summed from the registered read data
                if (remain_reg != '0)
                begin
                    ram_re      = 1'b1;
                    addr_next   = addr_inc;
                    remain_next = remain_reg - wmar_pkg::CNT_W'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg)
                begin
                    acc_next = acc_reg + wmar_pkg::SUM_W'(ram_rdata);
                end
                if ((remain_reg == '0) && !pend_reg)
                begin
                    q_next     = wmar_pkg::QUOT_W'(acc_reg);
                    rem_next   = '0;
                    divc_next  = wmar_pkg::DIVC_W'(wmar_pkg::QUOT_W - 1);
                    state_next = wmar_pkg::ST_DIVIDE;
                end
            end

            wmar_pkg::ST_DIVIDE:
            begin
                // one quotient bit per cycle
                if (trial_ge)
                begin
                    rem_next = wmar_pkg::CNT_W'(trial - (wmar_pkg::CNT_W + 1)'(win_reg));
                end
                else
                begin
                    rem_next = trial[wmar_pkg::CNT_W-1:0];
                end
                q_next    = {q_reg[wmar_pkg::QUOT_W-2:0], trial_ge};
                divc_next = divc_reg - wmar_pkg::DIVC_W'(1);
                if (divc_reg == '0)
                begin
                    state_next = wmar_pkg::ST_DONE;
                end
            end

            wmar_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = wmar_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = wmar_pkg::ST_IDLE;
            end
        endcase
    end

    assign average_value = q_reg[wmar_pkg::OUT_BITS-1:0];

endmodule

`default_nettype wire

@@ rtl/wmar_checker.sv @@
// port-level checks for the moving average ring, bound to the top level
// depends on wmar_pkg and windowed_moving_average_ring_defines.svh
`default_nettype none

`include "windowed_moving_average_ring_defines.svh"

module wmar_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        action,
    input wire logic [7:0]  window_size,
    input wire logic        done,
    input wire logic [15:0] average_value
);

    logic take_push;
    logic take_query;

    assign take_push  = start && !busy && (action == wmar_pkg::ACT_PUSH);
    assign take_query = start && !busy && (action == wmar_pkg::ACT_QUERY);

    // a result only appears while a query holds the block
    `WMAR_ASSERT_SAME(a_done_while_busy, done, busy)
    // a query request makes the block go busy
    `WMAR_ASSERT_NEXT(a_query_goes_busy, take_query, busy)
    // a push request never produces a result
    `WMAR_ASSERT_NEXT(a_push_no_result, take_push, !done)
    // an empty window answers zero in the next cycle
    `WMAR_ASSERT_NEXT(a_empty_window, take_query && (window_size == 8'd0),
                      done && (average_value == 16'd0))
    // one strobe per result
    `WMAR_ASSERT_NEXT(a_single_strobe, done, !done)

endmodule

bind windowed_moving_average_ring wmar_checker u_wmar_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .window_size   (window_size),
    .done          (done),
    .average_value (average_value)
);

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the windowed moving average ring
// drives push and query requests, predicts each mean, compares on every done strobe
// depends on wmar_pkg and windowed_moving_average_ring
`timescale 1ns / 100ps

module testbench;

    localparam int STORE_DEPTH  = wmar_pkg::DEPTH;
    localparam int RING_AW      = wmar_pkg::ADDR_W;
    localparam int RANDOM_ITEMS = 730;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [15:0] sample_value;
    logic [7:0]  window_size;
    logic        done;
    logic [15:0] average_value;

    // predicted ring contents and write position
    logic [wmar_pkg::SAMPLE_BITS-1:0] ring_samples [STORE_DEPTH];
    int unsigned                      ring_wr_pos;

    // means still owed by the block, oldest first
    logic [15:0] expected_means [$];
    logic [15:0] mean_due;

    int mismatch_count;
    int cycle_count;
    int items_sent;
    bit no_idle;

    windowed_moving_average_ring dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .sample_value  (sample_value),
        .window_size   (window_size),
        .done          (done),
        .average_value (average_value)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached with %0d means outstanding", $time,
                     expected_means.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // truncated mean of the most recent samples, window clamped to the store depth
    function automatic logic [15:0] window_mean(input logic [7:0] win_req);
        int unsigned win;
        int unsigned first;
        int unsigned i;
        logic [63:0] total;
        win = 32'(win_req);
        if (win > STORE_DEPTH)
            win = STORE_DEPTH;
        if (win == 0)
            return 16'd0;
        first = (ring_wr_pos + STORE_DEPTH - win) % STORE_DEPTH;
        total = 64'd0;
        for (i = 0; i < win; i++)
            total += 64'(ring_samples[RING_AW'((first + i) % STORE_DEPTH)]);
        return 16'(total / 64'(win));
    endfunction

    // one request, held until taken; the model is updated at the accepting edge
    task automatic send_request(input logic act, input logic [15:0] value,
                                input logic [7:0] win);
        start        <= 1'b1;
        action       <= act;
        sample_value <= value;
        window_size  <= win;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (act == wmar_pkg::ACT_QUERY)
            expected_means.push_back(window_mean(win));
        else
        begin
            ring_samples[RING_AW'(ring_wr_pos)] = value;
            ring_wr_pos = (ring_wr_pos + 1) % STORE_DEPTH;
        end
        items_sent++;
    endtask

    // drop start for a while, with junk on the request fields
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start        <= 1'b0;
            action       <= 1'($urandom);
            sample_value <= 16'($urandom);
            window_size  <= 8'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // mostly short gaps, a few long ones, none during a burst stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(150, 10);
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'hFFFF;
        else if (r < 15)
            return 16'h0000;
        else
            return 16'($urandom);
    endfunction

    // small windows mostly, some up to the depth, a few oversized
    function automatic logic [7:0] pick_window();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 8'($urandom_range(16, 0));
        else if (r < 85)
            return 8'($urandom_range(STORE_DEPTH, 17));
        else
            return 8'($urandom_range(255, STORE_DEPTH + 1));
    endfunction

    task automatic push_sample(input logic [15:0] value);
        send_request(wmar_pkg::ACT_PUSH, value, 8'($urandom));
        hold_off(pick_gap());
    endtask

    task automatic query_mean(input logic [7:0] win);
        send_request(wmar_pkg::ACT_QUERY, 16'($urandom), win);
        hold_off(pick_gap());
    endtask

    // store cleared by reset: every window averages to zero
    task automatic test_cleared_store();
        query_mean(8'd0);
        query_mean(8'd1);
        query_mean(8'd128);
        query_mean(8'd255);
    endtask

    // extreme samples, empty and oversized windows, window wrapping past slot zero
    task automatic test_window_edges();
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        push_sample(16'hAAAA);
        push_sample(16'h5555);
        query_mean(8'd0);
        query_mean(8'd1);
        query_mean(8'd2);
        query_mean(8'd4);
        query_mean(8'd5);
        query_mean(8'd127);
        query_mean(8'd128);
        query_mean(8'd129);
        query_mean(8'd255);
        push_sample(16'hFFFF);
        query_mean(8'd3);
    endtask

    // random pushes and queries, with the odd full refill of the ring
    task automatic test_random_traffic();
        int i;
        bit all_max;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 2)
                no_idle = !no_idle;
            if ($urandom_range(199) < 3)
            begin
                // fill the whole ring then average all of it
                all_max = 1'($urandom_range(1));
                for (i = 0; i < STORE_DEPTH + $urandom_range(12); i++)
                    push_sample(all_max ? 16'hFFFF : pick_sample());
                query_mean(8'd128);
                query_mean(8'($urandom_range(255, STORE_DEPTH)));
            end
            else if ($urandom_range(99) < 55)
                push_sample(pick_sample());
            else
                query_mean(pick_window());
        end
    endtask

    // result check on every done strobe
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_means.size() == 0)
            begin
                $display("%0t: average_value expected none, actual %0d", $time,
                         average_value);
                mismatch_count++;
            end
            else
            begin
                mean_due = expected_means.pop_front();
                if (average_value !== mean_due)
                begin
                    $display("%0t: average_value expected %0d, actual %0d", $time,
                             mean_due, average_value);
                    mismatch_count++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        no_idle        = 1'b0;
        ring_wr_pos    = 0;
        for (int s = 0; s < STORE_DEPTH; s++)
            ring_samples[RING_AW'(s)] = '0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        action       <= wmar_pkg::ACT_PUSH;
        sample_value <= 16'd0;
        window_size  <= 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_store();
        test_window_edges();
        test_random_traffic();

        // drain outstanding means
        start <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
